// ===== rtl/core/mvcr_pkg.sv =====
`default_nettype none
package mvcr_pkg;

  localparam int unsigned IDX_W       = 16;
  localparam int unsigned NUM_CORNERS = 3;
  localparam int unsigned CORNER_W    = 2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_MAP,
    ST_RD_REV,
    ST_CHECK,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/core/mvcr_stream_if.sv =====
`default_nettype none
interface mvcr_tri_if
  import mvcr_pkg::*;
();
  logic valid;
  logic ready;
  logic new_mesh;
  logic tri_active;
  idx_t corner_a;
  idx_t corner_b;
  idx_t corner_c;

  modport source (
    output valid, new_mesh, tri_active, corner_a, corner_b, corner_c,
    input  ready
  );
  modport sink (
    input  valid, new_mesh, tri_active, corner_a, corner_b, corner_c,
    output ready
  );
endinterface

interface mvcr_remap_if
  import mvcr_pkg::*;
();
  logic valid;
  logic ready;
  idx_t old_vertex;
  idx_t new_vertex;
  logic last_of_triangle;

  modport source (
    output valid, old_vertex, new_vertex, last_of_triangle,
    input  ready
  );
  modport sink (
    input  valid, old_vertex, new_vertex, last_of_triangle,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/mesh_vertex_compaction_remap.sv =====
// Inactive triangle: accepted in the idle state, no beats out.
// Active triangle: each corner steps through map read, reverse read, and check and
// write on the map and reverse memories; then one result beat (0 to 3) per cycle
// while map_o.ready is high; the next triangle is taken the cycle after the last beat.
// Reset clears the sequencer and the assigned count only; no clearing pass runs, since
// an entry counts as assigned only when the reverse table points back at it.
`default_nettype none
module mesh_vertex_compaction_remap
  import mvcr_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 65536
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  mvcr_tri_if.sink     tri_i,
  mvcr_remap_if.source map_o
);

  localparam int unsigned DEPTH = (MAX_VERTICES < 65536) ? MAX_VERTICES : 65536;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0] DEPTH_EXT = (IDX_W+1)'(DEPTH);
  localparam logic [CW-1:0]  DEPTH_CNT = CW'(DEPTH);

  state_e state_q, state_d;

  logic [CW-1:0]       count_q, count_d;
  logic [CORNER_W-1:0] corner_q, corner_d;
  logic [CORNER_W-1:0] nres_q, nres_d;
  logic [CORNER_W-1:0] emit_q, emit_d;
  idx_t                corners_q [NUM_CORNERS];
  idx_t                res_old_q [NUM_CORNERS];
  idx_t                res_new_q [NUM_CORNERS];

  logic [AW-1:0] map_mem [DEPTH];
  logic [AW-1:0] rev_mem [DEPTH];
  logic [AW-1:0] map_rd_q;
  logic [AW-1:0] rev_rd_q;
  logic          below_q;

  idx_t            cur_idx;
  logic            in_range;
  logic            hit;
  logic            assign_en;
  logic            take;
  logic [IDX_W:0]  count_ext;

  assign cur_idx   = corners_q[corner_q];
  assign in_range  = {1'b0, cur_idx} < DEPTH_EXT;
  assign hit       = below_q && (rev_rd_q == cur_idx[AW-1:0]);
  assign count_ext = (IDX_W+1)'(count_q);
  assign take      = tri_i.valid && tri_i.ready;

  // Unwritten map entries read as unknown; leave the decision on the not-hit side.
  always_comb begin
    assign_en = 1'b0;
    if (state_q == ST_CHECK && in_range && count_q != DEPTH_CNT) begin
      if (hit) begin
        assign_en = 1'b0;
      end else begin
        assign_en = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    corner_d    = corner_q;
    nres_d      = nres_q;
    emit_d      = emit_q;
    tri_i.ready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        tri_i.ready = 1'b1;
        if (tri_i.valid) begin
          if (tri_i.new_mesh) begin
            count_d = '0;
          end
          if (tri_i.tri_active) begin
            corner_d = '0;
            nres_d   = '0;
            state_d  = ST_RD_MAP;
          end
        end
      end
      ST_RD_MAP: state_d = ST_RD_REV;
      ST_RD_REV: state_d = ST_CHECK;
      ST_CHECK: begin
        if (assign_en) begin
          count_d = count_q + CW'(1);
          nres_d  = nres_q + CORNER_W'(1);
        end
        if (corner_q == CORNER_W'(NUM_CORNERS - 1)) begin
          emit_d  = '0;
          state_d = (nres_d != '0) ? ST_EMIT : ST_IDLE;
        end else begin
          corner_d = corner_q + CORNER_W'(1);
          state_d  = ST_RD_MAP;
        end
      end
      ST_EMIT: begin
        if (map_o.ready) begin
          if (emit_q == nres_q - CORNER_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            emit_d = emit_q + CORNER_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      corner_q <= '0;
      nres_q   <= '0;
      emit_q   <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      corner_q <= corner_d;
      nres_q   <= nres_d;
      emit_q   <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      corners_q[0] <= tri_i.corner_a;
      corners_q[1] <= tri_i.corner_b;
      corners_q[2] <= tri_i.corner_c;
    end
    if (assign_en) begin
      res_old_q[nres_q] <= cur_idx;
      res_new_q[nres_q] <= count_ext[IDX_W-1:0];
    end
  end

  // Map: old index to slot. Read in map phase, written on assignment.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD_MAP) begin
      map_rd_q <= map_mem[cur_idx[AW-1:0]];
    end
    if (assign_en) begin
      map_mem[cur_idx[AW-1:0]] <= count_q[AW-1:0];
    end
  end

  // Reverse: slot back to old index; only slots below the count are live.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD_REV) begin
      rev_rd_q <= rev_mem[map_rd_q];
      below_q  <= CW'(map_rd_q) < count_q;
    end
    if (assign_en) begin
      rev_mem[count_q[AW-1:0]] <= cur_idx[AW-1:0];
    end
  end

  assign map_o.valid            = (state_q == ST_EMIT);
  assign map_o.old_vertex       = res_old_q[emit_q];
  assign map_o.new_vertex       = res_new_q[emit_q];
  assign map_o.last_of_triangle = (emit_q == nres_q - CORNER_W'(1));

endmodule
`default_nettype wire
